// ===== rtl/core/ehc_pkg.sv =====
// ============================================================================
// ehc_pkg: shared types and constants for the Ethernet header classifier.
// Holds the frame classes, the parse phases and the queue entry type.
// ============================================================================
`default_nettype none

package ehc_pkg;

    localparam int unsigned MaxFrameBytes = 65535;

    localparam int QueueDepth     = 4;
    localparam int QueuePtrBits   = $clog2(QueueDepth);
    localparam int QueueCountBits = QueuePtrBits + 1;

    localparam logic [15:0] EtherIpv4 = 16'h0800;
    localparam logic [15:0] EtherIpv6 = 16'h86dd;
    localparam logic [15:0] EtherArp  = 16'h0806;

    localparam logic [7:0] ProtoIcmp  = 8'd1;
    localparam logic [7:0] ProtoTcp   = 8'd6;
    localparam logic [7:0] ProtoUdp   = 8'd17;
    localparam logic [7:0] ProtoHop   = 8'd0;
    localparam logic [7:0] ProtoRoute = 8'd43;
    localparam logic [7:0] ProtoFrag  = 8'd44;
    localparam logic [7:0] ProtoIcmp6 = 8'd58;
    localparam logic [7:0] ProtoNone  = 8'd59;
    localparam logic [7:0] ProtoDest  = 8'd60;

    typedef enum logic [3:0] {
        CLS_V4_TCP    = 4'd0,
        CLS_V4_UDP    = 4'd1,
        CLS_V4_ICMP   = 4'd2,
        CLS_V6_TCP    = 4'd3,
        CLS_V6_UDP    = 4'd4,
        CLS_V6_ICMP   = 4'd5,
        CLS_V6_NONE   = 4'd6,
        CLS_ARP       = 4'd7,
        CLS_BAD_ETHER = 4'd8,
        CLS_BAD_IHL   = 4'd9,
        CLS_BAD_PROTO = 4'd10,
        CLS_BAD_V6    = 4'd11,
        CLS_BAD_PTYPE = 4'd12,
        CLS_SPARE_D   = 4'd13,
        CLS_SPARE_E   = 4'd14,
        CLS_SPARE_F   = 4'd15
    } frame_class_t;

    typedef enum logic [2:0] {
        PH_ETH  = 3'd0,
        PH_V4   = 3'd1,
        PH_V6   = 3'd2,
        PH_OPT  = 3'd3,
        PH_FRAG = 3'd4,
        PH_L4   = 3'd5,
        PH_ARP  = 3'd6,
        PH_DONE = 3'd7
    } parse_phase_t;

    typedef struct packed {
        logic [3:0]  frame_class;
        logic [31:0] port_pair;
        logic [63:0] address_pair;
        logic [47:0] sender_mac;
        logic [47:0] target_mac;
        logic [15:0] frame_length;
        logic        truncated;
    } result_t;

    function automatic logic [3:0] v6_terminal_class(input logic [7:0] t);
        logic [3:0] c;
        c = CLS_BAD_V6;
        if (t == ProtoTcp) c = CLS_V6_TCP;
        else if (t == ProtoUdp) c = CLS_V6_UDP;
        else if (t == ProtoIcmp6) c = CLS_V6_ICMP;
        else if (t == ProtoNone) c = CLS_V6_NONE;
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ehc_parser.sv =====
// ============================================================================
// ehc_parser: per-byte header parser.
// Walks the frame one byte per cycle while byte_en is high and emits one raw result per frame.
// ============================================================================
`default_nettype none

module ehc_parser
    import ehc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_en,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             res_valid,
    output result_t          res_data
);

    logic [15:0]  pos_reg, pos_next;
    logic [15:0]  ether_reg, ether_next;
    parse_phase_t phase_reg, phase_next;
    logic [7:0]   pend_reg, pend_next;
    logic [16:0]  l4_reg, l4_next;
    logic [3:0]   cls_reg, cls_next;
    logic [31:0]  port_reg, port_next;
    logic [63:0]  addr_reg, addr_next;
    logic [47:0]  mac0_reg, mac0_next;
    logic [47:0]  mac1_reg, mac1_next;
    logic         res_valid_reg;
    result_t      res_reg, res_next;

    logic         take;
    logic [16:0]  p17;
    logic [16:0]  p_rel;
    logic [3:0]   tcls;
    logic [3:0]   fcls;
    logic [15:0]  n_cnt;
    logic [3:0]   ihl;

    // Enter the IPv6 header held in pend_next at l4_next.
    function automatic void dispatch(
        input  logic [7:0]   t,
        input  logic [16:0]  pos,
        input  logic [16:0]  start,
        output parse_phase_t ph,
        output logic         set_cls,
        output logic [3:0]   c
    );
        logic [3:0] tc;
        tc = v6_terminal_class(t);
        set_cls = 1'b0;
        c = tc;
        if (t == ProtoHop || t == ProtoRoute || t == ProtoDest) ph = PH_OPT;
        else if (t == ProtoFrag) ph = PH_FRAG;
        else begin
            set_cls = 1'b1;
            if (tc == CLS_BAD_V6) ph = PH_DONE;
            else if ((tc == CLS_V6_ICMP || tc == CLS_V6_NONE) && (pos + 17'd1 >= start))
                ph = PH_DONE;
            else ph = PH_L4;
        end
    endfunction

    always_comb
    begin
        parse_phase_t dph;
        logic         dset;
        logic [3:0]   dc;
        logic [16:0]  nl4;
        pos_next   = pos_reg;
        ether_next = ether_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        l4_next    = l4_reg;
        cls_next   = cls_reg;
        port_next  = port_reg;
        addr_next  = addr_reg;
        mac0_next  = mac0_reg;
        mac1_next  = mac1_reg;
        res_next   = res_reg;
        dph = PH_DONE;
        dset = 1'b0;
        dc = '0;
        nl4 = '0;
        take = byte_en && (32'(pos_reg) < MaxFrameBytes);
        p17 = {1'b0, pos_reg};
        p_rel = p17 - l4_reg;
        ihl = data_byte[3:0];

        if (take) begin
            pos_next = pos_reg + 16'd1;
            case (phase_reg)
                PH_ETH:
                begin
                    if (pos_reg == 16'd12) ether_next = {data_byte, 8'h00};
                    if (pos_reg == 16'd13) begin
                        ether_next = {ether_reg[15:8], data_byte};
                        if (ether_next == EtherIpv4) phase_next = PH_V4;
                        else if (ether_next == EtherIpv6) phase_next = PH_V6;
                        else if (ether_next == EtherArp) phase_next = PH_ARP;
                        else begin
                            cls_next = CLS_BAD_ETHER;
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_V4:
                begin
                    if (pos_reg == 16'd14) begin
                        if (ihl < 4'd5) begin
                            cls_next = CLS_BAD_IHL;
                            phase_next = PH_DONE;
                        end else begin
                            l4_next = 17'd14 + {11'd0, ihl, 2'b00};
                        end
                    end else if (pos_reg == 16'd23) begin
                        if (data_byte == ProtoTcp) cls_next = CLS_V4_TCP;
                        else if (data_byte == ProtoUdp) cls_next = CLS_V4_UDP;
                        else if (data_byte == ProtoIcmp) cls_next = CLS_V4_ICMP;
                        else begin
                            cls_next = CLS_BAD_PROTO;
                            phase_next = PH_DONE;
                        end
                    end else if (pos_reg >= 16'd26 && pos_reg <= 16'd33) begin
                        // Source address lands in the upper word, byte 26 on top.
                        addr_next[{3'(16'd33 - pos_reg), 3'b000} +: 8] = data_byte;
                        if (pos_reg == 16'd33)
                            phase_next = (cls_reg == CLS_V4_ICMP) ? PH_DONE : PH_L4;
                    end
                end
                PH_V6:
                begin
                    if (pos_reg == 16'd20) pend_next = data_byte;
                    if (pos_reg == 16'd53) begin
                        l4_next = 17'd54;
                        dispatch(pend_reg, p17, 17'd54, dph, dset, dc);
                        phase_next = dph;
                        if (dset) cls_next = dc;
                    end
                end
                PH_OPT:
                begin
                    if (p17 == l4_reg) begin
                        pend_next = data_byte;
                    end else if (p17 == l4_reg + 17'd1) begin
                        nl4 = l4_reg + {3'd0, ({3'd0, data_byte} + 11'd1), 3'b000};
                        l4_next = nl4;
                        dispatch(pend_reg, p17, nl4, dph, dset, dc);
                        phase_next = dph;
                        if (dset) cls_next = dc;
                    end
                end
                PH_FRAG:
                begin
                    if (p17 == l4_reg) begin
                        pend_next = data_byte;
                        nl4 = l4_reg + 17'd8;
                        l4_next = nl4;
                        dispatch(data_byte, p17, nl4, dph, dset, dc);
                        phase_next = dph;
                        if (dset) cls_next = dc;
                    end
                end
                PH_L4:
                begin
                    if (cls_reg == CLS_V4_TCP || cls_reg == CLS_V4_UDP ||
                        cls_reg == CLS_V6_TCP || cls_reg == CLS_V6_UDP) begin
                        if (p17 >= l4_reg && p_rel < 17'd4)
                            port_next[8*(3-p_rel[1:0]) +: 8] = data_byte;
                        if (p17 == l4_reg + 17'd3) phase_next = PH_DONE;
                    end else if (p17 + 17'd1 >= l4_reg) begin
                        phase_next = PH_DONE;
                    end
                end
                PH_ARP:
                begin
                    if (pos_reg == 16'd16) pend_next = data_byte;
                    else if (pos_reg == 16'd17) begin
                        if ({pend_reg, data_byte} == EtherIpv4) cls_next = CLS_ARP;
                        else begin
                            cls_next = CLS_BAD_PTYPE;
                            phase_next = PH_DONE;
                        end
                    end else if (pos_reg >= 16'd22 && pos_reg <= 16'd27) begin
                        mac0_next[8*(5-(pos_reg[5:0]-6'd22)) +: 8] = data_byte;
                    end else if (pos_reg >= 16'd28 && pos_reg <= 16'd31) begin
                        addr_next[8*(7-(pos_reg[1:0])) +: 8] = data_byte;
                    end else if (pos_reg >= 16'd32 && pos_reg <= 16'd37) begin
                        mac1_next[8*(5-(pos_reg[5:0]-6'd32)) +: 8] = data_byte;
                    end else if (pos_reg >= 16'd38 && pos_reg <= 16'd41) begin
                        addr_next[8*(3-(pos_reg[5:0]-6'd38)) +: 8] = data_byte;
                        if (pos_reg == 16'd41) phase_next = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Final classification of a frame that ends on this byte.
        n_cnt = pos_next;
        tcls = v6_terminal_class(pend_next);
        case (phase_next)
            PH_ETH:  fcls = (ether_next == EtherIpv4) ? CLS_BAD_IHL : CLS_BAD_ETHER;
            PH_V4:   fcls = (n_cnt <= 16'd14) ? CLS_BAD_IHL :
                            (n_cnt <= 16'd23) ? CLS_BAD_PROTO : cls_next;
            PH_V6, PH_OPT, PH_FRAG: fcls = tcls;
            PH_ARP:
            begin
                if (n_cnt <= 16'd16) fcls = CLS_BAD_PTYPE;
                else if (n_cnt == 16'd17)
                    fcls = (pend_next == 8'h08) ? CLS_ARP : CLS_BAD_PTYPE;
                else fcls = cls_next;
            end
            default: fcls = cls_next;
        endcase

        if (byte_en && last_byte) begin
            res_next.frame_class  = fcls;
            res_next.port_pair    = (fcls == CLS_V4_TCP || fcls == CLS_V4_UDP ||
                                     fcls == CLS_V6_TCP || fcls == CLS_V6_UDP)
                                    ? port_next : 32'd0;
            res_next.address_pair = (fcls <= CLS_V4_ICMP || fcls == CLS_ARP)
                                    ? addr_next : 64'd0;
            res_next.sender_mac   = (fcls == CLS_ARP) ? mac0_next : 48'd0;
            res_next.target_mac   = (fcls == CLS_ARP) ? mac1_next : 48'd0;
            res_next.frame_length = n_cnt;
            res_next.truncated    = (phase_next != PH_DONE);
            pos_next   = '0;
            ether_next = '0;
            phase_next = PH_ETH;
            pend_next  = '0;
            l4_next    = '0;
            cls_next   = '0;
            port_next  = '0;
            addr_next  = '0;
            mac0_next  = '0;
            mac1_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= '0;
            ether_reg     <= '0;
            phase_reg     <= PH_ETH;
            pend_reg      <= '0;
            l4_reg        <= '0;
            cls_reg       <= '0;
            port_reg      <= '0;
            addr_reg      <= '0;
            mac0_reg      <= '0;
            mac1_reg      <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            ether_reg     <= ether_next;
            phase_reg     <= phase_next;
            pend_reg      <= pend_next;
            l4_reg        <= l4_next;
            cls_reg       <= cls_next;
            port_reg      <= port_next;
            addr_reg      <= addr_next;
            mac0_reg      <= mac0_next;
            mac1_reg      <= mac1_next;
            res_valid_reg <= byte_en && last_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ehc_result_queue.sv =====
// ============================================================================
// ehc_result_queue: small result FIFO between parser and output port.
// Holds finished results until the consumer takes them.
// ============================================================================
`default_nettype none

module ehc_result_queue
    import ehc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  result_t      push_data,
    input  wire logic    pop,
    output logic         not_empty,
    output logic         almost_full,
    output result_t      head
);

    result_t                   mem [QueueDepth];
    logic [QueuePtrBits-1:0]   wr_reg, wr_next;
    logic [QueuePtrBits-1:0]   rd_reg, rd_next;
    logic [QueueCountBits-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_next  = push ? wr_reg + QueuePtrBits'(1) : wr_reg;
        rd_next  = pop ? rd_reg + QueuePtrBits'(1) : rd_reg;
        cnt_next = cnt_reg + QueueCountBits'(push) - QueueCountBits'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_reg] <= push_data;
    end

    assign not_empty   = (cnt_reg != '0);
    // One slot kept in reserve: one result may be in the parser register.
    assign almost_full = (cnt_reg >= QueueCountBits'(QueueDepth - 1));
    assign head        = mem[rd_reg];

    assert property (@(posedge clk) disable iff (!rst_n)
                     !(push && cnt_reg == QueueCountBits'(QueueDepth)))
        else $error("result queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && cnt_reg == '0))
        else $error("result queue underflow");
    assert property (@(posedge clk) disable iff (!rst_n)
                     cnt_reg <= QueueCountBits'(QueueDepth))
        else $error("result queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/ethernet_ip_header_classifier_core.sv =====
// ============================================================================
// ethernet_ip_header_classifier_core: Ethernet/IPv4/IPv6/ARP header classifier.
// Accepts one frame byte per request and returns one result per frame.
// ============================================================================
// Result path: the result of a frame is registered in the parser, then written into the queue.
// Throughput: one byte per cycle; ready drops only when the result queue
// holds three or more untaken results.
// Reset: rst_n clears the parse state and empties the queue asynchronously.
`default_nettype none

module ethernet_ip_header_classifier_core
    import ehc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       frame_class,
    output logic [15:0]      src_port,
    output logic [15:0]      dst_port,
    output logic [31:0]      source_ipv4,
    output logic [31:0]      dest_ipv4,
    output logic [47:0]      sender_mac,
    output logic [47:0]      target_mac,
    output logic [15:0]      frame_length,
    output logic             truncated
);

    logic    byte_en;
    logic    res_valid;
    result_t res_data;
    logic    not_empty;
    logic    almost_full;
    result_t head;

    // The front end takes a byte whenever the queue has room for any result
    // already in flight plus the one this byte might finish.
    assign in_ready = !almost_full;
    assign byte_en  = in_valid && in_ready;

    ehc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    ehc_result_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (res_valid),
        .push_data   (res_data),
        .pop         (out_valid && out_ready),
        .not_empty   (not_empty),
        .almost_full (almost_full),
        .head        (head)
    );

    assign out_valid    = not_empty;
    assign frame_class  = head.frame_class;
    assign src_port     = head.port_pair[31:16];
    assign dst_port     = head.port_pair[15:0];
    assign source_ipv4  = head.address_pair[63:32];
    assign dest_ipv4    = head.address_pair[31:0];
    assign sender_mac   = head.sender_mac;
    assign target_mac   = head.target_mac;
    assign frame_length = head.frame_length;
    assign truncated    = head.truncated;

endmodule

`default_nettype wire

// ===== bench/ethernet_ip_header_classifier_core_test.sv =====
// ============================================================================
// ethernet_ip_header_classifier_core_test: self-checking bench for the core.
// Drives generated frames one byte per request, builds its own expected result
// for each frame from a byte-level predictor, and compares every result field.
// ============================================================================
`default_nettype none

module ethernet_ip_header_classifier_core_test;
    import ehc_pkg::*;

    localparam int StallLimit = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  frame_class;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] source_ipv4;
    logic [31:0] dest_ipv4;
    logic [47:0] sender_mac;
    logic [47:0] target_mac;
    logic [15:0] frame_length;
    logic        truncated;

    ethernet_ip_header_classifier_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .frame_class(frame_class), .src_port(src_port), .dst_port(dst_port),
        .source_ipv4(source_ipv4), .dest_ipv4(dest_ipv4),
        .sender_mac(sender_mac), .target_mac(target_mac),
        .frame_length(frame_length), .truncated(truncated)
    );

    // Predictor state, mirrored byte by byte from the parser's behavior.
    int unsigned  pos_count;
    logic [15:0]  kind_seen;
    parse_phase_t phase;
    logic [7:0]   next_hdr;
    int unsigned  hdr_start;
    logic [3:0]   cls_acc;
    logic [31:0]  ports_acc;
    logic [63:0]  addrs_acc;
    logic [47:0]  smac_acc;
    logic [47:0]  tmac_acc;

    result_t     expected_results[$];
    int          mismatch_count;
    int          idle_cycles;
    bit          hold_receiver;
    int          bytes_sent;

    // Burst shaping for the sender.
    int          burst_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [3:0] v6_class_of(input logic [7:0] t);
        if (t == ProtoTcp) return CLS_V6_TCP;
        if (t == ProtoUdp) return CLS_V6_UDP;
        if (t == ProtoIcmp6) return CLS_V6_ICMP;
        if (t == ProtoNone) return CLS_V6_NONE;
        return CLS_BAD_V6;
    endfunction

    function automatic bit has_ports(input logic [3:0] c);
        return c == CLS_V4_TCP || c == CLS_V4_UDP || c == CLS_V6_TCP || c == CLS_V6_UDP;
    endfunction

    task automatic clear_parse_state();
        pos_count = 0;
        kind_seen = '0;
        phase     = PH_ETH;
        next_hdr  = '0;
        hdr_start = 0;
        cls_acc   = '0;
        ports_acc = '0;
        addrs_acc = '0;
        smac_acc  = '0;
        tmac_acc  = '0;
    endtask

    // Step into the IPv6 header whose type is waiting in next_hdr.
    task automatic enter_v6_header(input int unsigned pos);
        if (next_hdr == ProtoHop || next_hdr == ProtoRoute || next_hdr == ProtoDest)
            phase = PH_OPT;
        else if (next_hdr == ProtoFrag)
            phase = PH_FRAG;
        else
        begin
            cls_acc = v6_class_of(next_hdr);
            if (cls_acc == CLS_BAD_V6)
                phase = PH_DONE;
            else if ((cls_acc == CLS_V6_ICMP || cls_acc == CLS_V6_NONE) && pos + 1 >= hdr_start)
                phase = PH_DONE;
            else
                phase = PH_L4;
        end
    endtask

    task automatic parse_one_byte(input int unsigned pos, input logic [7:0] b);
        case (phase)
            PH_ETH:
            begin
                if (pos == 12) kind_seen = {b, 8'h00};
                if (pos == 13)
                begin
                    kind_seen[7:0] = b;
                    if (kind_seen == EtherIpv4) phase = PH_V4;
                    else if (kind_seen == EtherIpv6) phase = PH_V6;
                    else if (kind_seen == EtherArp) phase = PH_ARP;
                    else
                    begin
                        cls_acc = CLS_BAD_ETHER;
                        phase = PH_DONE;
                    end
                end
            end
            PH_V4:
            begin
                if (pos == 14)
                begin
                    if (b[3:0] < 5)
                    begin
                        cls_acc = CLS_BAD_IHL;
                        phase = PH_DONE;
                    end
                    else hdr_start = 14 + b[3:0] * 4;
                end
                else if (pos == 23)
                begin
                    if (b == ProtoTcp) cls_acc = CLS_V4_TCP;
                    else if (b == ProtoUdp) cls_acc = CLS_V4_UDP;
                    else if (b == ProtoIcmp) cls_acc = CLS_V4_ICMP;
                    else
                    begin
                        cls_acc = CLS_BAD_PROTO;
                        phase = PH_DONE;
                    end
                end
                else if (pos >= 26 && pos <= 33)
                begin
                    addrs_acc[8 * (7 - (pos - 26)) +: 8] = b;
                    if (pos == 33) phase = (cls_acc == CLS_V4_ICMP) ? PH_DONE : PH_L4;
                end
            end
            PH_V6:
            begin
                if (pos == 20) next_hdr = b;
                if (pos == 53)
                begin
                    hdr_start = 54;
                    enter_v6_header(pos);
                end
            end
            PH_OPT:
            begin
                if (pos == hdr_start) next_hdr = b;
                else if (pos == hdr_start + 1)
                begin
                    hdr_start += (b + 1) * 8;
                    enter_v6_header(pos);
                end
            end
            PH_FRAG:
            begin
                if (pos == hdr_start)
                begin
                    next_hdr = b;
                    hdr_start += 8;
                    enter_v6_header(pos);
                end
            end
            PH_L4:
            begin
                if (has_ports(cls_acc))
                begin
                    if (pos >= hdr_start && pos < hdr_start + 4)
                        ports_acc[8 * (3 - (pos - hdr_start)) +: 8] = b;
                    if (pos == hdr_start + 3) phase = PH_DONE;
                end
                else if (pos + 1 >= hdr_start) phase = PH_DONE;
            end
            PH_ARP:
            begin
                if (pos == 16) next_hdr = b;
                else if (pos == 17)
                begin
                    if ({next_hdr, b} == EtherIpv4) cls_acc = CLS_ARP;
                    else
                    begin
                        cls_acc = CLS_BAD_PTYPE;
                        phase = PH_DONE;
                    end
                end
                else if (pos >= 22 && pos <= 27) smac_acc[8 * (5 - (pos - 22)) +: 8] = b;
                else if (pos >= 28 && pos <= 31) addrs_acc[8 * (7 - (pos - 28)) +: 8] = b;
                else if (pos >= 32 && pos <= 37) tmac_acc[8 * (5 - (pos - 32)) +: 8] = b;
                else if (pos >= 38 && pos <= 41)
                begin
                    addrs_acc[8 * (3 - (pos - 38)) +: 8] = b;
                    if (pos == 41) phase = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Feed one accepted byte; on the frame's last byte, queue its result.
    task automatic predict_classification(input logic [7:0] b, input logic last);
        result_t r;
        logic [3:0] c;
        if (pos_count < MaxFrameBytes)
        begin
            parse_one_byte(pos_count, b);
            pos_count++;
        end
        if (last)
        begin
            case (phase)
                PH_ETH: c = (kind_seen == EtherIpv4) ? CLS_BAD_IHL : CLS_BAD_ETHER;
                PH_V4: c = (pos_count <= 14) ? CLS_BAD_IHL :
                           (pos_count <= 23) ? CLS_BAD_PROTO : cls_acc;
                PH_V6, PH_OPT, PH_FRAG: c = v6_class_of(next_hdr);
                PH_ARP:
                begin
                    if (pos_count <= 16) c = CLS_BAD_PTYPE;
                    else if (pos_count == 17) c = (next_hdr == 8'h08) ? CLS_ARP : CLS_BAD_PTYPE;
                    else c = cls_acc;
                end
                default: c = cls_acc;
            endcase
            r = '0;
            r.frame_class = c;
            if (has_ports(c)) r.port_pair = ports_acc;
            if (c <= CLS_V4_ICMP || c == CLS_ARP) r.address_pair = addrs_acc;
            if (c == CLS_ARP)
            begin
                r.sender_mac = smac_acc;
                r.target_mac = tmac_acc;
            end
            r.frame_length = pos_count[15:0];
            r.truncated = (phase != PH_DONE);
            expected_results.push_back(r);
            clear_parse_state();
        end
    endtask

    // Offer one byte; valid stays up until it is taken. Bursts and gaps are
    // decided here so the sender idles at random points within frames.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do @(posedge clk); while (!in_ready);
        predict_classification(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] f[]);
        foreach (f[i]) send_byte(f[i], i == f.size() - 1);
    endtask

    // Frame builders. Each fills a random body and then plants header fields.
    function automatic void fill_random(ref logic [7:0] f[], input int n);
        f = new[n];
        foreach (f[i]) f[i] = 8'($urandom());
    endfunction

    function automatic void put_ether(ref logic [7:0] f[], input logic [15:0] et);
        if (f.size() > 12) f[12] = et[15:8];
        if (f.size() > 13) f[13] = et[7:0];
    endfunction

    function automatic void build_ipv4(ref logic [7:0] f[], input logic [7:0] proto,
                                       input int ihl, input int n);
        fill_random(f, n);
        put_ether(f, EtherIpv4);
        if (n > 14) f[14] = {4'h4, ihl[3:0]};
        if (n > 23) f[23] = proto;
    endfunction

    // IPv6 with a chain of extension headers; ext lengths kept small.
    function automatic void build_ipv6(ref logic [7:0] f[], input int n_ext,
                                       input logic [7:0] final_type, input int tail);
        int p;
        logic [7:0] t;
        logic [7:0] kinds[4];
        kinds = '{ProtoHop, ProtoRoute, ProtoDest, ProtoFrag};
        fill_random(f, 54 + n_ext * 32 + tail);
        put_ether(f, EtherIpv6);
        p = 54;
        t = (n_ext > 0) ? kinds[$urandom_range(0, 3)] : final_type;
        f[20] = t;
        for (int k = 0; k < n_ext; k++)
        begin
            logic [7:0] nt;
            nt = (k == n_ext - 1) ? final_type : kinds[$urandom_range(0, 3)];
            f[p] = nt;
            if (t == ProtoFrag) p += 8;
            else
            begin
                f[p + 1] = 8'($urandom_range(0, 2));
                p += (f[p + 1] + 1) * 8;
            end
            t = nt;
        end
        f = new[p + tail](f);
    endfunction

    function automatic void build_arp(ref logic [7:0] f[], input bit good_ptype, input int n);
        fill_random(f, n);
        put_ether(f, EtherArp);
        if (good_ptype && n > 17)
        begin
            f[16] = 8'h08;
            f[17] = 8'h00;
        end
    endfunction

    // Any frame, mostly well formed; sometimes cut short anywhere.
    function automatic void build_any(ref logic [7:0] f[]);
        int sel;
        logic [7:0] pr[3];
        logic [7:0] fin[5];
        pr  = '{ProtoTcp, ProtoUdp, ProtoIcmp};
        fin = '{ProtoTcp, ProtoUdp, ProtoIcmp6, ProtoNone, 8'd99};
        sel = $urandom_range(0, 9);
        if (sel < 4)
            build_ipv4(f, ($urandom_range(0, 9) == 0) ? 8'($urandom()) : pr[$urandom_range(0, 2)],
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 7),
                       $urandom_range(38, 70));
        else if (sel < 7)
            build_ipv6(f, $urandom_range(0, 3), fin[$urandom_range(0, 4)], $urandom_range(0, 8));
        else if (sel < 9)
            build_arp(f, $urandom_range(0, 7) != 0, $urandom_range(40, 60));
        else
            fill_random(f, $urandom_range(1, 60));
        if ($urandom_range(0, 5) == 0) f = new[$urandom_range(1, f.size())](f);
    endfunction

    task automatic test_ethernet_edges();
        logic [7:0] f[];
        fill_random(f, 1);
        f[0] = 8'hff;
        send_frame(f);
        fill_random(f, 13);
        f[12] = 8'h08;
        send_frame(f);
        fill_random(f, 20);
        foreach (f[i]) f[i] = 8'h00;
        send_frame(f);
        fill_random(f, 20);
        foreach (f[i]) f[i] = 8'hff;
        send_frame(f);
    endtask

    task automatic test_ipv4_cases();
        logic [7:0] f[];
        build_ipv4(f, ProtoTcp, 5, 38);
        send_frame(f);
        build_ipv4(f, ProtoUdp, 15, 78);
        send_frame(f);
        build_ipv4(f, ProtoIcmp, 5, 34);
        send_frame(f);
        build_ipv4(f, ProtoTcp, 4, 40);
        send_frame(f);
        build_ipv4(f, 8'd200, 5, 40);
        send_frame(f);
        build_ipv4(f, ProtoTcp, 5, 15);
        send_frame(f);
        build_ipv4(f, ProtoUdp, 5, 30);
        send_frame(f);
    endtask

    task automatic test_ipv6_chain();
        logic [7:0] f[];
        build_ipv6(f, 0, ProtoTcp, 4);
        send_frame(f);
        build_ipv6(f, 3, ProtoUdp, 4);
        send_frame(f);
        build_ipv6(f, 2, ProtoIcmp6, 0);
        send_frame(f);
        build_ipv6(f, 1, ProtoNone, 2);
        send_frame(f);
        build_ipv6(f, 1, 8'd99, 2);
        send_frame(f);
        build_ipv6(f, 2, ProtoTcp, 0);
        f = new[f.size() - 10](f);
        send_frame(f);
    endtask

    task automatic test_arp_cases();
        logic [7:0] f[];
        build_arp(f, 1, 42);
        send_frame(f);
        build_arp(f, 0, 42);
        send_frame(f);
        build_arp(f, 1, 17);
        send_frame(f);
        build_arp(f, 1, 30);
        send_frame(f);
    endtask

    task automatic test_random_frames();
        logic [7:0] f[];
        while (bytes_sent < 1900)
        begin
            build_any(f);
            send_frame(f);
        end
    endtask

    // A long receiver hold-off while frames keep coming, so the queue fills.
    task automatic test_backpressure();
        logic [7:0] f[];
        hold_receiver = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            fill_random(f, $urandom_range(1, 3));
            send_frame(f);
        end
    endtask

    // Result checker and receiver stall pattern.
    int hold_count;
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result, class %0d", frame_class);
                mismatch_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (frame_class !== exp_r.frame_class)
                begin
                    $error("frame_class exp %0d got %0d", exp_r.frame_class, frame_class);
                    mismatch_count++;
                end
                if (src_port !== exp_r.port_pair[31:16])
                begin
                    $error("src_port exp %h got %h", exp_r.port_pair[31:16], src_port);
                    mismatch_count++;
                end
                if (dst_port !== exp_r.port_pair[15:0])
                begin
                    $error("dst_port exp %h got %h", exp_r.port_pair[15:0], dst_port);
                    mismatch_count++;
                end
                if (source_ipv4 !== exp_r.address_pair[63:32])
                begin
                    $error("source_ipv4 exp %h got %h", exp_r.address_pair[63:32], source_ipv4);
                    mismatch_count++;
                end
                if (dest_ipv4 !== exp_r.address_pair[31:0])
                begin
                    $error("dest_ipv4 exp %h got %h", exp_r.address_pair[31:0], dest_ipv4);
                    mismatch_count++;
                end
                if (sender_mac !== exp_r.sender_mac)
                begin
                    $error("sender_mac exp %h got %h", exp_r.sender_mac, sender_mac);
                    mismatch_count++;
                end
                if (target_mac !== exp_r.target_mac)
                begin
                    $error("target_mac exp %h got %h", exp_r.target_mac, target_mac);
                    mismatch_count++;
                end
                if (frame_length !== exp_r.frame_length)
                begin
                    $error("frame_length exp %0d got %0d", exp_r.frame_length, frame_length);
                    mismatch_count++;
                end
                if (truncated !== exp_r.truncated)
                begin
                    $error("truncated exp %0d got %0d", exp_r.truncated, truncated);
                    mismatch_count++;
                end
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    // The receiver changes ready at the falling edge; a long hold-off is counted
    // here while the sender keeps offering requests.
    always @(negedge clk)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else if (hold_receiver)
        begin
            out_ready <= 1'b0;
            if (hold_count >= 300)
            begin
                hold_receiver <= 1'b0;
                hold_count <= 0;
            end
            else hold_count <= hold_count + 1;
        end
        else if (bytes_sent % 512 < 128) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        idle_cycles = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_cycles > StallLimit)
            begin
                $display("ethernet_ip_header_classifier_core_test: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        mismatch_count = 0;
        hold_receiver = 1'b0;
        hold_count = 0;
        bytes_sent = 0;
        burst_left = 0;
        clear_parse_state();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_ethernet_edges();
        test_ipv4_cases();
        test_ipv6_chain();
        test_arp_cases();
        test_backpressure();
        test_random_frames();

        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("ethernet_ip_header_classifier_core_test: PASS");
        else
            $display("ethernet_ip_header_classifier_core_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
